>>> rtl/core/lpfc_pkg.sv
// Shared types and constants for the length-prefixed frame checker.
`timescale 1ns / 1ps

package lpfc_pkg;

  localparam int unsigned MAX_TAG_BYTES = 8;
  localparam int unsigned CHECK_BYTES   = 4;
  localparam logic [15:0] ADLER_MOD     = 16'd65521;

  typedef enum logic [1:0] {
    REG_TAG_WORD   = 2'd0,
    REG_TAG_LENGTH = 2'd1,
    REG_MIN_LENGTH = 2'd2,
    REG_MAX_LENGTH = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_BODY   = 3'b010,
    PH_HALT   = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    V_OK         = 2'd0,
    V_BAD_LENGTH = 2'd1,
    V_CHECKSUM   = 2'd2,
    V_BAD_TAG    = 2'd3
  } verdict_t;

  typedef enum logic {
    K_PAYLOAD = 1'b0,
    K_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    logic [63:0] tag_word;
    logic [3:0]  tag_length;
    logic [31:0] min_length;
    logic [31:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  verdict;
    logic [31:0] body_length;
  } result_t;

endpackage

>>> rtl/core/lpfc_if.sv
// Channel interfaces: byte input, result output and register write port.
`timescale 1ns / 1ps

interface lpfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface lpfc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [1:0]  verdict;
  logic [31:0] body_length;
  modport source (output valid, output kind, output payload_byte, output verdict,
                  output body_length, input ready);
  modport sink   (input valid, input kind, input payload_byte, input verdict,
                  input body_length, output ready);
endinterface

interface lpfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/length_prefixed_frame_checker.sv
// Top level of the length-prefixed frame checker with Adler-32 check.
//
//   channel  direction  payload                                   handshake
//   in_if    in         stream_byte[7:0]                          valid/ready
//   out_if   out        kind, payload_byte, verdict, body_length  valid/ready
//   cfg_if   in         index[1:0], data[63:0]                    valid/ready
//
// One byte per cycle while the result register is not stalled: a beat lands in the input
// register, passes the frame logic and leaves through the result register.
// Ready stays high while the result register is empty or being drained.
// rst_n is synchronous; after reset the block waits for a length header.
// After an error verdict every byte is taken and dropped until reset.
`timescale 1ns / 1ps

module length_prefixed_frame_checker
  import lpfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lpfc_in_if.sink     in_if,
  lpfc_out_if.source  out_if,
  lpfc_cfg_if.sink    cfg_if
);

  cfg_t        cfg;
  logic        s0_valid;
  logic [7:0]  s0_byte;
  logic        stage_en;
  logic        step;
  logic        res_valid;
  result_t     res;
  logic        out_valid_r, out_valid_nxt;
  result_t     result_r;

  lpfc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // advance only when the result register is free or draining
  assign stage_en = !out_valid_r || out_if.ready;
  assign step     = s0_valid && stage_en;

  lpfc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .advance  (stage_en),
    .s0_valid (s0_valid),
    .s0_byte  (s0_byte)
  );

  lpfc_frame_core u_frame_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .s0_byte   (s0_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    if (step) begin
      out_valid_nxt = res_valid;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      result_r <= res;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = result_r.kind;
  assign out_if.payload_byte = result_r.payload_byte;
  assign out_if.verdict      = result_r.verdict;
  assign out_if.body_length  = result_r.body_length;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |-> !step)
    else $error("result register overwritten while stalled");

endmodule

>>> rtl/core/lpfc_cfg_regs.sv
// Configuration register file written through the cfg channel.
`timescale 1ns / 1ps

module lpfc_cfg_regs
  import lpfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  lpfc_cfg_if.sink         cfg_if,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_reg_t'(cfg_if.index))
        REG_TAG_WORD:   cfg_nxt.tag_word   = cfg_if.data;
        REG_TAG_LENGTH: cfg_nxt.tag_length = cfg_if.data[3:0];
        REG_MIN_LENGTH: cfg_nxt.min_length = cfg_if.data[31:0];
        REG_MAX_LENGTH: cfg_nxt.max_length = cfg_if.data[31:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tag_word   <= 64'd0;
      cfg_r.tag_length <= 4'd0;
      cfg_r.min_length <= 32'd4;
      cfg_r.max_length <= 32'd67108864;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/core/lpfc_in_stage.sv
// Input register: holds one accepted beat until the frame logic takes it.
`timescale 1ns / 1ps

module lpfc_in_stage (
  input  logic        clk,
  input  logic        rst_n,
  lpfc_in_if.sink     in_if,
  input  logic        advance,
  output logic        s0_valid,
  output logic [7:0]  s0_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       take;

  assign in_if.ready = !valid_r || advance;
  assign take        = in_if.valid && in_if.ready;
  assign s0_valid    = valid_r;
  assign s0_byte     = byte_r;

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_if.stream_byte;
    end
  end

endmodule

>>> rtl/core/lpfc_frame_core.sv
// Frame parser: length header, tag check, running Adler-32 and verdict.
`timescale 1ns / 1ps

module lpfc_frame_core
  import lpfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  s0_byte,
  input  cfg_t        cfg,
  output logic        res_valid,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] header_shift_r, header_shift_nxt;
  logic [31:0] frame_length_r, frame_length_nxt;
  logic [31:0] byte_count_r, byte_count_nxt;
  logic [15:0] adler_low_r, adler_low_nxt;
  logic [15:0] adler_high_r, adler_high_nxt;
  logic        tag_matches_r, tag_matches_nxt;
  logic [31:0] received_sum_r, received_sum_nxt;

  logic [3:0]  tl;
  logic [31:0] count_inc;
  logic [31:0] header_word;
  logic        len_bad;
  logic [31:0] data_len;
  logic        in_data;
  logic        in_tag;
  logic [16:0] low_sum;
  logic [15:0] low_new;
  logic [16:0] high_sum;
  logic [15:0] high_new;
  logic [7:0]  want;
  logic [31:0] rx_word;
  logic        last_byte;

  assign tl          = (cfg.tag_length > 4'(MAX_TAG_BYTES)) ? 4'(MAX_TAG_BYTES)
                                                           : cfg.tag_length;
  assign count_inc   = byte_count_r + 32'd1;
  assign header_word = {header_shift_r[23:0], s0_byte};
  assign len_bad     = (header_word < cfg.min_length) || (header_word > cfg.max_length) ||
                       (header_word < ({28'd0, tl} + 32'(CHECK_BYTES)));
  assign data_len    = frame_length_r - 32'(CHECK_BYTES);
  assign in_data     = byte_count_r < data_len;
  assign in_tag      = byte_count_r < {28'd0, tl};
  assign want        = cfg.tag_word[{byte_count_r[2:0], 3'b000} +: 8];
  assign rx_word     = {received_sum_r[23:0], s0_byte};
  assign last_byte   = !(count_inc < frame_length_r);

  // Adler-32 step: both sums stay below the modulus, so one subtract each
  assign low_sum  = {1'b0, adler_low_r} + {9'd0, s0_byte};
  assign low_new  = (low_sum >= {1'b0, ADLER_MOD}) ? 16'(low_sum - {1'b0, ADLER_MOD})
                                                  : low_sum[15:0];
  assign high_sum = {1'b0, adler_high_r} + {1'b0, low_new};
  assign high_new = (high_sum >= {1'b0, ADLER_MOD}) ? 16'(high_sum - {1'b0, ADLER_MOD})
                                                   : high_sum[15:0];

  always_comb begin
    phase_nxt        = phase_r;
    header_shift_nxt = header_shift_r;
    frame_length_nxt = frame_length_r;
    byte_count_nxt   = byte_count_r;
    adler_low_nxt    = adler_low_r;
    adler_high_nxt   = adler_high_r;
    tag_matches_nxt  = tag_matches_r;
    received_sum_nxt = received_sum_r;
    res_valid        = 1'b0;
    res.kind         = K_PAYLOAD;
    res.payload_byte = 8'd0;
    res.verdict      = V_OK;

    case (phase_r)
      PH_HEADER: begin
        header_shift_nxt = header_word;
        byte_count_nxt   = count_inc;
        if (!(count_inc < 32'(CHECK_BYTES))) begin
          frame_length_nxt = header_word;
          header_shift_nxt = 32'd0;
          byte_count_nxt   = 32'd0;
          if (len_bad) begin
            phase_nxt   = PH_HALT;
            res_valid   = 1'b1;
            res.kind    = K_VERDICT;
            res.verdict = V_BAD_LENGTH;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        byte_count_nxt = count_inc;
        if (in_data) begin
          adler_low_nxt  = low_new;
          adler_high_nxt = high_new;
          if (in_tag) begin
            if (want != s0_byte) begin
              tag_matches_nxt = 1'b0;
            end
          end else begin
            res_valid        = 1'b1;
            res.payload_byte = s0_byte;
          end
        end else begin
          received_sum_nxt = rx_word;
          if (last_byte) begin
            res_valid = 1'b1;
            res.kind  = K_VERDICT;
            if ({adler_high_r, adler_low_r} != rx_word) begin
              res.verdict = V_CHECKSUM;
            end else if (!tag_matches_r) begin
              res.verdict = V_BAD_TAG;
            end
            if (res.verdict != V_OK) begin
              phase_nxt = PH_HALT;
            end else begin
              // open the next frame
              phase_nxt        = PH_HEADER;
              header_shift_nxt = 32'd0;
              byte_count_nxt   = 32'd0;
              adler_low_nxt    = 16'd1;
              adler_high_nxt   = 16'd0;
              tag_matches_nxt  = 1'b1;
              received_sum_nxt = 32'd0;
            end
          end
        end
      end
      PH_HALT: begin
        phase_nxt = PH_HALT;
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase

    res.body_length = frame_length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      header_shift_r <= 32'd0;
      frame_length_r <= 32'd0;
      byte_count_r   <= 32'd0;
      adler_low_r    <= 16'd1;
      adler_high_r   <= 16'd0;
      tag_matches_r  <= 1'b1;
      received_sum_r <= 32'd0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      header_shift_r <= header_shift_nxt;
      frame_length_r <= frame_length_nxt;
      byte_count_r   <= byte_count_nxt;
      adler_low_r    <= adler_low_nxt;
      adler_high_r   <= adler_high_nxt;
      tag_matches_r  <= tag_matches_nxt;
      received_sum_r <= received_sum_nxt;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |=> phase_r == PH_HALT)
    else $error("frame core left halt without reset");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.kind == K_VERDICT && res.verdict != V_OK
      |=> phase_r == PH_HALT)
    else $error("error verdict did not halt the block");

  a_adler_range: assert property (@(posedge clk) disable iff (!rst_n)
    adler_low_r < ADLER_MOD && adler_high_r < ADLER_MOD)
    else $error("Adler sums out of range");

endmodule

>>> dv/tb.sv
// Self-checking bench for the length-prefixed frame checker: byte stream in, results checked.
`timescale 1ns / 1ps

module tb;
  import lpfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned ROUND_BYTES = 330;
  localparam int unsigned ROUNDS      = 6;
  localparam int unsigned SHOW_LIMIT  = 10;
  localparam int          FILL_RANDOM = -1;

  typedef logic [7:0] octet_q_t[$];

  // how the run is brought to its halt
  typedef enum int unsigned {
    END_ABOVE_MAX,
    END_SHORT_FOR_TAG,
    END_BELOW_MIN,
    END_BAD_SUM,
    END_BAD_TAG
  } ending_t;

  logic clk;
  logic rst_n;

  lpfc_in_if  in_ch ();
  lpfc_out_if out_ch ();
  lpfc_cfg_if cfg_ch ();

  length_prefixed_frame_checker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // shadow registers and tracked frame state
  cfg_t        live_cfg;
  phase_t      trk_phase;
  logic [31:0] trk_shift;
  logic [31:0] trk_len;
  logic [31:0] trk_count;
  logic [31:0] trk_sum;
  logic [15:0] trk_lo;
  logic [15:0] trk_hi;
  logic        trk_tag_ok;

  result_t     frame_outputs[$];
  octet_q_t    stream_q;

  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned bytes_taken   = 0;
  int unsigned payload_seen  = 0;
  int unsigned verdicts_seen = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  verdict_t    last_verdict  = V_OK;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned tag_bytes_in_use();
    return (live_cfg.tag_length > MAX_TAG_BYTES) ? MAX_TAG_BYTES : live_cfg.tag_length;
  endfunction

  function automatic void open_frame();
    trk_phase  = PH_HEADER;
    trk_shift  = '0;
    trk_count  = '0;
    trk_lo     = 16'd1;
    trk_hi     = '0;
    trk_tag_ok = 1'b1;
    trk_sum    = '0;
  endfunction

  // advance the tracked frame by one received byte, queue whatever it yields
  function automatic void follow_byte(input logic [7:0] b);
    int unsigned te;
    logic [31:0] pos;
    logic [16:0] acc;
    result_t     r;
    te = tag_bytes_in_use();
    r  = '0;
    case (trk_phase)
      PH_HEADER: begin
        trk_shift = {trk_shift[23:0], b};
        trk_count = trk_count + 1;
        if (trk_count == CHECK_BYTES) begin
          trk_len   = trk_shift;
          trk_shift = '0;
          trk_count = '0;
          if (trk_len < live_cfg.min_length || trk_len > live_cfg.max_length ||
              trk_len < te + CHECK_BYTES) begin
            trk_phase     = PH_HALT;
            r.kind        = K_VERDICT;
            r.verdict     = V_BAD_LENGTH;
            r.body_length = trk_len;
            frame_outputs.push_back(r);
          end else begin
            trk_phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        pos       = trk_count;
        trk_count = trk_count + 1;
        if (pos < trk_len - CHECK_BYTES) begin
          acc = trk_lo + b;
          if (acc >= ADLER_MOD) acc = acc - ADLER_MOD;
          trk_lo = acc[15:0];
          acc = trk_hi + trk_lo;
          if (acc >= ADLER_MOD) acc = acc - ADLER_MOD;
          trk_hi = acc[15:0];
          if (pos < te) begin
            if (live_cfg.tag_word[8*pos[2:0] +: 8] != b) trk_tag_ok = 1'b0;
          end else begin
            r.kind         = K_PAYLOAD;
            r.payload_byte = b;
            r.body_length  = trk_len;
            frame_outputs.push_back(r);
          end
        end else begin
          trk_sum = {trk_sum[23:0], b};
          if (trk_count == trk_len) begin
            r.kind        = K_VERDICT;
            r.body_length = trk_len;
            if ({trk_hi, trk_lo} != trk_sum) r.verdict = V_CHECKSUM;
            else if (!trk_tag_ok)            r.verdict = V_BAD_TAG;
            else                             r.verdict = V_OK;
            frame_outputs.push_back(r);
            if (r.verdict == V_OK) open_frame();
            else trk_phase = PH_HALT;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // frame with the current tag length; fill < 0 gives random payload bytes
  function automatic void build_frame(input logic [63:0] tag, input int unsigned pay_len,
                                      input bit bad_tag, input bit bad_sum, input int fill,
                                      output octet_q_t frame);
    octet_q_t    body;
    int unsigned te, lo, hi, k;
    logic [31:0] sum;
    logic [31:0] len;
    te = tag_bytes_in_use();
    for (int i = 0; i < te; i++) body.push_back(tag[8*i +: 8]);
    for (int i = 0; i < pay_len; i++) body.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    if (bad_tag && te != 0) begin
      k = $urandom_range(te - 1);
      body[k] = body[k] ^ 8'($urandom_range(1, 255));
    end
    lo = 1;
    hi = 0;
    foreach (body[i]) begin
      lo = (lo + body[i]) % ADLER_MOD;
      hi = (hi + lo) % ADLER_MOD;
    end
    sum = {hi[15:0], lo[15:0]};
    if (bad_sum) begin
      k = $urandom_range(3);
      sum[8*k +: 8] = sum[8*k +: 8] ^ 8'($urandom_range(1, 255));
    end
    len   = body.size() + CHECK_BYTES;
    frame = {len[31:24], len[23:16], len[15:8], len[7:0]};
    frame = {frame, body, sum[31:24], sum[23:16], sum[15:8], sum[7:0]};
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_TAG_WORD:   live_cfg.tag_word   = value;
      REG_TAG_LENGTH: live_cfg.tag_length = value[3:0];
      REG_MIN_LENGTH: live_cfg.min_length = value[31:0];
      REG_MAX_LENGTH: live_cfg.max_length = value[31:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  // upper data bits are junk on purpose: the block must mask them
  task automatic set_regs(input logic [63:0] tag, input logic [3:0] tl,
                          input logic [31:0] mn, input logic [31:0] mx);
    write_reg(REG_TAG_WORD, tag);
    write_reg(REG_TAG_LENGTH, {$urandom, 28'($urandom), tl});
    write_reg(REG_MIN_LENGTH, {$urandom, mn});
    write_reg(REG_MAX_LENGTH, {$urandom, mx});
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (stream_q.size() != 0 || in_ch.valid || frame_outputs.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        follow_byte(in_ch.stream_byte);
        bytes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (stream_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_ch.valid       <= 1'b1;
          in_ch.stream_byte <= stream_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_check
    result_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind         = out_ch.kind;
        got.payload_byte = out_ch.payload_byte;
        got.verdict      = out_ch.verdict;
        got.body_length  = out_ch.body_length;
        if (got.kind == K_PAYLOAD) begin
          payload_seen++;
        end else begin
          verdicts_seen++;
          last_verdict = verdict_t'(got.verdict);
        end
        if (frame_outputs.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: result with nothing outstanding: kind %0d byte %h verdict %0d len %0d",
                     $time, got.kind, got.payload_byte, got.verdict, got.body_length);
        end else begin
          want = frame_outputs.pop_front();
          if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
              got.verdict !== want.verdict || got.body_length !== want.body_length) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
              $display("%0t: mismatch: want kind %0d byte %h verdict %0d len %0d / got %0d %h %0d %0d",
                       $time, want.kind, want.payload_byte, want.verdict, want.body_length,
                       got.kind, got.payload_byte, got.verdict, got.body_length);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, frame_outputs.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    octet_q_t    frame;
    logic [63:0] new_tag;
    logic [31:0] bad_len, mn, mx;
    logic [3:0]  tl;
    int unsigned te, lo_pay, hi_pay, span, cap, built;
    int          fill;
    bit          big;
    ending_t     ending;

    in_ch.valid       = 1'b0;
    in_ch.stream_byte = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_TAG_WORD;
    cfg_ch.data       = '0;
    rst_n             = 1'b0;
    live_cfg = '{tag_word: '0, tag_length: '0, min_length: 32'd4, max_length: 32'd67108864};
    trk_len = '0;
    open_frame();
    in_idle_pct   = 19;
    out_stall_pct = 53;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty payload, then the two payload byte extremes
    build_frame(live_cfg.tag_word, 0, 1'b0, 1'b0, FILL_RANDOM, frame);
    stream_q = {stream_q, frame};
    build_frame(live_cfg.tag_word, 1, 1'b0, 1'b0, 8'h00, frame);
    stream_q = {stream_q, frame};
    build_frame(live_cfg.tag_word, 1, 1'b0, 1'b0, 8'hFF, frame);
    stream_q = {stream_q, frame};
    wait_drained();

    for (int r = 0; r < ROUNDS; r++) begin
      in_idle_pct   = (r < 2) ? 19 : (r < 4) ? 53 : 0;
      out_stall_pct = (r < 2) ? 53 : (r < 4) ? 19 : 0;
      case (r)
        0: set_regs('1, 4'd8, 32'd12, '1);
        1: set_regs({$urandom, $urandom}, 4'd15, 32'd4, 32'd4096);
        2: set_regs('0, 4'd0, 32'd4, 32'd4);
        default: begin
          tl = 4'($urandom_range(15));
          te = (tl > MAX_TAG_BYTES) ? MAX_TAG_BYTES : tl;
          mn = te + CHECK_BYTES + $urandom_range(3);
          mx = mn + $urandom_range(50, 700);
          set_regs({$urandom, $urandom}, tl, mn, mx);
        end
      endcase

      if (r == 0) begin
        // change the tag word between the third and fourth tag byte
        new_tag        = {$urandom, $urandom};
        new_tag[23:0]  = live_cfg.tag_word[23:0];
        build_frame(new_tag, $urandom_range(1, 8), 1'b0, 1'b0, FILL_RANDOM, frame);
        stream_q = {stream_q, frame[0:6]};
        wait_drained();
        write_reg(REG_TAG_WORD, new_tag);
        stream_q = {stream_q, frame[7:$]};
      end
      if (r == 1) begin
        // long run of ones forces both Adler halves to wrap
        build_frame(live_cfg.tag_word, 300, 1'b0, 1'b0, 8'hFF, frame);
        stream_q = {stream_q, frame};
      end

      built = 0;
      while (built < ROUND_BYTES) begin
        te     = tag_bytes_in_use();
        lo_pay = (live_cfg.min_length > te + CHECK_BYTES) ?
                 live_cfg.min_length - te - CHECK_BYTES : 0;
        hi_pay = live_cfg.max_length - te - CHECK_BYTES;
        big    = ($urandom_range(19) == 0);
        span   = hi_pay - lo_pay;
        cap    = big ? 700 : 24;
        if (span > cap) span = cap;
        if ((big && $urandom_range(1) == 1) || $urandom_range(9) == 0) fill = 8'hFF;
        else fill = FILL_RANDOM;
        build_frame(live_cfg.tag_word, lo_pay + $urandom_range(span), 1'b0, 1'b0, fill, frame);
        stream_q = {stream_q, frame};
        built += frame.size();
      end
      wait_drained();
    end

    // one error to finish with; the block stays halted afterwards
    ending = ending_t'($urandom_range(END_BAD_TAG));
    tl = (ending == END_SHORT_FOR_TAG) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(1, 15));
    te = (tl > MAX_TAG_BYTES) ? MAX_TAG_BYTES : tl;
    mn = te + CHECK_BYTES + $urandom_range(20);
    mx = mn + $urandom_range(300);
    if (ending == END_SHORT_FOR_TAG) mn = 32'd4;
    if (ending == END_BELOW_MIN && $urandom_range(1) == 1) begin
      mn = '1;
      mx = '1;
    end
    set_regs({$urandom, $urandom}, tl, mn, mx);
    case (ending)
      END_ABOVE_MAX:     bad_len = ($urandom_range(1) == 1) ? mx + 1 : {1'b1, 31'($urandom)};
      END_SHORT_FOR_TAG: bad_len = $urandom_range(te + CHECK_BYTES - 1);
      END_BELOW_MIN:     bad_len = mn - 1;
      default:           bad_len = '0;
    endcase
    // keep the length legal so the frame reaches its checksum
    if (ending == END_BAD_SUM || ending == END_BAD_TAG)
      build_frame(live_cfg.tag_word,
                  $urandom_range(mn - te - CHECK_BYTES, mx - te - CHECK_BYTES),
                  ending == END_BAD_TAG || $urandom_range(1) == 1,
                  ending == END_BAD_SUM, FILL_RANDOM, frame);
    else
      frame = {bad_len[31:24], bad_len[23:16], bad_len[15:8], bad_len[7:0]};
    stream_q = {stream_q, frame};
    // drop: nothing after the error verdict may come out
    repeat (20) stream_q.push_back(8'($urandom));
    wait_drained();

    $display("summary: %0d bytes taken, %0d payload beats and %0d verdicts checked",
             bytes_taken, payload_seen, verdicts_seen);
    $display("summary: %0d register settings, halted by %s, last verdict %s, %0d mismatches",
             ROUNDS + 2, ending.name(), last_verdict.name(), mismatches);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/lpfc_pkg.sv
rtl/core/lpfc_if.sv
rtl/core/lpfc_cfg_regs.sv
rtl/core/lpfc_in_stage.sv
rtl/core/lpfc_frame_core.sv
rtl/core/length_prefixed_frame_checker.sv
dv/tb.sv
